@@ hw/rtl/color_class_labeler_defines.svh @@
// Assertion macros shared by the colour class labeller RTL.
// Users need a clk and an active-low arst_n in scope.
`ifndef COLOR_CLASS_LABELER_DEFINES_SVH
`define COLOR_CLASS_LABELER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cclab_pkg.sv @@
// Package for the colour class labeller: field widths, codes, FSM and control types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cclab_pkg;

	localparam int LABEL_W     = 4;
	localparam int HITS_W      = 24;
	localparam int SIZE_W      = 5;
	localparam int STATUS_W    = 2;
	localparam int IN_CHAN_W   = 8;
	localparam int IN_CHANS    = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 3;
	localparam int CHAN_CFG_W  = 3;

	localparam logic [CHAN_CFG_W-1:0] CHAN_COUNT_RESET = 3'd3;

	// Preset table: null, blue and red over the first three channels
	localparam int PRESET_FULL        = 255;
	localparam int PRESET_BLUE_CHAN   = 2;
	localparam int PRESET_RED_CHAN    = 0;
	localparam int PRESET_BASE_SIZE   = 1;
	localparam int PRESET_BINARY_SIZE = 3;
	localparam int PRESET_BLUE_IDX    = 1;
	localparam int PRESET_RED_IDX     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN    = 2'd0,
		CFG_CHANNELS = 2'd1,
		CFG_PRESET   = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_MATCH = 2'd0,
		STAT_ADDED = 2'd1,
		STAT_MISS  = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic load_preset;
		logic binary;
		logic append;
	} tbl_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/color_class_labeler.sv @@
// Colour class labeller top level: control FSM, configuration registers, hit count memory.
// Depends on cclab_pkg, cclab_table, cclab_ram and color_class_labeler_defines.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  pixel in | start, busy           | restart, chan_a, chan_b, chan_c, chan_d
//  result   | done (one-cycle mark) | class_label, class_hits, table_size, status
//  config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// An item steps through the compare, select and write-back states; busy is high in each,
// and the result is registered onto the ports as it leaves write-back, when the next item
// may already be accepted. The states hold the registered compare over the colour table,
// the registered read of the hit count memory and its write-back; only one item is in flight.
// Reset leaves the null class only, all counts zero, label mode, three channels.
// The receiver cannot stall: done marks each result for exactly one cycle; the ports hold it until the next one.
`timescale 1ns / 1ps
`default_nettype none

`include "color_class_labeler_defines.svh"

module color_class_labeler import cclab_pkg::*; #(
	parameter int MAX_CLASSES  = 16,
	parameter int MAX_CHANNELS = 4,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  restart,
	input  logic [IN_CHAN_W-1:0]  chan_a,
	input  logic [IN_CHAN_W-1:0]  chan_b,
	input  logic [IN_CHAN_W-1:0]  chan_c,
	input  logic [IN_CHAN_W-1:0]  chan_d,
	output logic                  done,
	output logic [LABEL_W-1:0]    class_label,
	output logic [HITS_W-1:0]     class_hits,
	output logic [SIZE_W-1:0]     table_size,
	output logic [STATUS_W-1:0]   status,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int TOT_W = $clog2(MAX_CLASSES + 1);

	state_t state_q, state_d;
	logic   accept;

	logic                  learn_mode_q;
	logic [CHAN_CFG_W-1:0] chan_count_q;
	logic                  binary_preset_q;

	logic [IN_CHANS-1:0][IN_CHAN_W-1:0]       chan_in;
	logic [MAX_CHANNELS-1:0][CHANNEL_BITS-1:0] px_in;
	logic [MAX_CHANNELS-1:0][CHANNEL_BITS-1:0] px_s1;
	logic [MAX_CHANNELS-1:0]                   chan_en;

	logic [TOT_W-1:0]       total_q;
	logic [MAX_CLASSES-1:0] cnt_valid_q;
	logic [MAX_CLASSES-1:0] hit_s2;
	tbl_ctl_t               tbl_ctl;

	logic             sel_found;
	logic [IDX_W-1:0] sel_label;
	logic [IDX_W-1:0] sel_idx;
	status_t          sel_status;
	logic             full;

	logic [IDX_W-1:0] label_s3;
	status_t          status_s3;

	logic [HITS_W-1:0] cnt_rdata;
	logic [HITS_W-1:0] cnt_cur;
	logic [HITS_W-1:0] cnt_new;
	logic              cnt_we;

	logic                done_q;
	logic [LABEL_W-1:0]  class_label_q;
	logic [HITS_W-1:0]   class_hits_q;
	logic [SIZE_W-1:0]   table_size_q;
	status_t             status_q;

	// Configuration port: writes only land while idle
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_mode_q    <= 1'b0;
			chan_count_q    <= CHAN_COUNT_RESET;
			binary_preset_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEARN:    learn_mode_q    <= cfg_data[0];
				CFG_CHANNELS: chan_count_q    <= cfg_data[CHAN_CFG_W-1:0];
				CFG_PRESET:   binary_preset_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Channel 0 is always compared; a count above the limit enables every channel
	always_comb begin
		for (int b = 0; b < MAX_CHANNELS; b++) begin
			chan_en[b] = (b == 0) || ((CHAN_CFG_W + 1)'(b) < {1'b0, chan_count_q});
		end
	end

	assign chan_in = {chan_d, chan_c, chan_b, chan_a};

	for (genvar gb = 0; gb < MAX_CHANNELS; gb++) begin : g_px
		if (gb < IN_CHANS) begin : g_wired
			assign px_in[gb] = CHANNEL_BITS'(chan_in[gb]);
		end else begin : g_absent
			assign px_in[gb] = '0;
		end
	end

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign full   = (total_q >= TOT_W'(MAX_CLASSES));

	// Lowest matching row wins
	always_comb begin
		sel_found = |hit_s2;
		sel_label = '0;
		for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
			if (hit_s2[i]) begin
				sel_label = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d             = state_q;
		tbl_ctl.load_preset = accept && restart && learn_mode_q;
		tbl_ctl.binary      = binary_preset_q;
		tbl_ctl.append      = 1'b0;
		sel_idx             = '0;
		sel_status          = STAT_MISS;

		priority if (sel_found) begin
			sel_idx    = sel_label;
			sel_status = STAT_MATCH;
		end else if (!learn_mode_q) begin
			sel_status = STAT_MISS;
		end else if (full) begin
			sel_status = STAT_FULL;
		end else begin
			sel_idx    = total_q[IDX_W-1:0];
			sel_status = STAT_ADDED;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: state_d = ST_SEL;
			ST_SEL: begin
				tbl_ctl.append = (sel_status == STAT_ADDED);
				state_d        = ST_WB;
			end
			ST_WB: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= px_in;
		end
		if (state_q == ST_SEL) begin
			label_s3  <= sel_idx;
			status_s3 <= sel_status;
		end
	end

	// Table size and count-valid bits; an invalid count reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= TOT_W'(PRESET_BASE_SIZE);
			cnt_valid_q <= '0;
		end else begin
			if (tbl_ctl.load_preset) begin
				total_q <= binary_preset_q ? TOT_W'(PRESET_BINARY_SIZE)
				                           : TOT_W'(PRESET_BASE_SIZE);
			end else if (tbl_ctl.append) begin
				total_q <= total_q + TOT_W'(1);
			end

			if (accept && restart) begin
				cnt_valid_q <= '0;
			end else if (tbl_ctl.append) begin
				cnt_valid_q[sel_idx] <= 1'b0;
			end else if (cnt_we) begin
				cnt_valid_q[label_s3] <= 1'b1;
			end
		end
	end

	cclab_table #(
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_CHANNELS (MAX_CHANNELS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.new_idx (sel_idx),
		.px      (px_s1),
		.chan_en (chan_en),
		.total   (total_q),
		.hit_s2  (hit_s2)
	);

	// Read the count in the select cycle, saturate and write it back in the write-back state
	assign cnt_cur = cnt_valid_q[label_s3] ? cnt_rdata : '0;
	assign cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + HITS_W'(1);
	assign cnt_we  = (state_q == ST_WB) && !learn_mode_q && (status_s3 == STAT_MATCH);

	cclab_ram #(
		.WIDTH (HITS_W),
		.DEPTH (MAX_CLASSES)
	) u_hit_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (label_s3),
		.wdata (cnt_new),
		.re    ((state_q == ST_SEL) && sel_found && !learn_mode_q),
		.raddr (sel_label),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WB);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB) begin
			class_label_q <= LABEL_W'(label_s3);
			class_hits_q  <= cnt_we ? cnt_new : '0;
			table_size_q  <= SIZE_W'(total_q);
			status_q      <= status_s3;
		end
	end

	assign done        = done_q;
	assign class_label = class_label_q;
	assign class_hits  = class_hits_q;
	assign table_size  = table_size_q;
	assign status      = status_q;

	`CCL_ASSERT_NEXT(a_accept_to_cmp, accept, state_q == ST_CMP, "accepted item did not enter compare")
	`CCL_ASSERT_NOW(a_done_after_wb, done_q, $past(state_q == ST_WB), "result strobe without write-back")
	`CCL_ASSERT_NOW(a_append_room, tbl_ctl.append, total_q < TOT_W'(MAX_CLASSES), "append into full table")
	`CCL_ASSERT_NOW(a_hits_on_match, done_q && (class_hits_q != '0), status_q == STAT_MATCH, "hit count on non-match")

endmodule

`default_nettype wire

@@ hw/rtl/cclab_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cclab_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/cclab_table.sv @@
// Class colour table held in flops, with a parallel compare against every row.
// Depends on cclab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cclab_table import cclab_pkg::*; #(
	parameter int MAX_CLASSES  = 16,
	parameter int MAX_CHANNELS = 4,
	parameter int CHANNEL_BITS = 8,
	localparam int IDX_W = $clog2(MAX_CLASSES),
	localparam int TOT_W = $clog2(MAX_CLASSES + 1)
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  tbl_ctl_t                                  ctl,
	input  logic [IDX_W-1:0]                          new_idx,
	input  logic [MAX_CHANNELS-1:0][CHANNEL_BITS-1:0] px,
	input  logic [MAX_CHANNELS-1:0]                   chan_en,
	input  logic [TOT_W-1:0]                          total,
	output logic [MAX_CLASSES-1:0]                    hit_s2
);

	localparam logic [CHANNEL_BITS-1:0] FULL_VAL = CHANNEL_BITS'(PRESET_FULL);

	// Row 0 is the null class and stays zero, so it needs no storage
	logic [CHANNEL_BITS-1:0] colors_q [1:MAX_CLASSES-1][MAX_CHANNELS];
	logic [MAX_CLASSES-1:0]  hit_c;

	always_ff @(posedge clk) begin
		if (ctl.load_preset && ctl.binary) begin
			for (int b = 0; b < MAX_CHANNELS; b++) begin
				colors_q[PRESET_BLUE_IDX][b] <= (b == PRESET_BLUE_CHAN) ? FULL_VAL : '0;
				colors_q[PRESET_RED_IDX][b]  <= (b == PRESET_RED_CHAN) ? FULL_VAL : '0;
			end
		end
		if (ctl.append) begin
			// channels beyond the count in force are stored as zero
			for (int b = 0; b < MAX_CHANNELS; b++) begin
				colors_q[new_idx][b] <= chan_en[b] ? px[b] : '0;
			end
		end
	end

	for (genvar gi = 0; gi < MAX_CLASSES; gi++) begin : g_row
		logic [MAX_CHANNELS-1:0] ch_eq;
		for (genvar gb = 0; gb < MAX_CHANNELS; gb++) begin : g_ch
			if (gi == 0) begin : g_null
				assign ch_eq[gb] = !chan_en[gb] || (px[gb] == '0);
			end else begin : g_stored
				assign ch_eq[gb] = !chan_en[gb] || (px[gb] == colors_q[gi][gb]);
			end
		end
		assign hit_c[gi] = (TOT_W'(gi) < total) && (&ch_eq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= '0;
		end else begin
			hit_s2 <= hit_c;
		end
	end

endmodule

`default_nettype wire
